@@ src/rtpf_pkg.sv @@
// Package for the RTPS topic packet filter: field widths, layout codes, verdict codes.
// No dependencies.
`timescale 1ns / 1ps
package rtpf_pkg;
    localparam int TableEntriesDef = 16;
    localparam int MaxFrameBytesDef = 2047;
    localparam logic [31:0] SedpEntity = 32'h0000_03C2;
    localparam logic [7:0] SubInfoTs = 8'h09;
    localparam logic [7:0] SubData = 8'h15;
    localparam logic [7:0] SubInfoDst = 8'h0e;

    typedef enum logic [1:0] {
        LAY_NONE = 2'd0, LAY_TS = 2'd1, LAY_DST = 2'd2, LAY_THIRD = 2'd3
    } t_layout;

    typedef enum logic [1:0] {
        CAUSE_PASS = 2'd0, CAUSE_TOPIC = 2'd1, CAUSE_PAIR = 2'd2, CAUSE_BOTH = 2'd3
    } t_cause;

    // job handed from front to back at frame end
    typedef struct packed {
        logic         filt;
        logic [255:0] topic;
        logic [255:0] pair;
    } t_job;
endpackage

@@ src/rtpf_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rtpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/rtpf_front.sv @@
// Front end: parses frame bytes, gathers topic and source address.
// Depends on rtpf_pkg.
`timescale 1ns / 1ps
module rtpf_front #(
    parameter int MAX_FRAME_BYTES = rtpf_pkg::MaxFrameBytesDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_byte_vld,
    input  logic [7:0]    i_byte,
    input  logic          i_end,
    output rtpf_pkg::t_job o_job
);
    import rtpf_pkg::*;
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    logic [PW-1:0]  r_pos;
    logic [6:0]     r_rs;
    logic [7:0]     r_topic [32];
    logic [31:0]    r_src, r_gw;
    logic           r_eth, r_udp, r_mag, r_third, r_ent, r_len;
    t_layout        r_lay;

    logic           take;
    logic [PW-1:0]  p, off;
    logic           in_r;
    t_layout        lay_a, lay_b;
    logic [6:0]     es, ls, ts;
    logic [31:0]    gw_n, gw_sh;
    logic           eth_n, udp_n, mag_n, third_n, ent_n, len_n;
    logic [31:0]    src_n;
    logic [6:0]     rs_n;
    logic [PW:0]    len_tot, need;
    logic           cut;
    logic [7:0]     tb [32];

    always_comb begin
        take = (r_pos < PW'(MAX_FRAME_BYTES));
        p = r_pos;
        in_r = take && (p > PW'(14)) && (p >= PW'(r_rs));
        off = p - PW'(r_rs);
        gw_n = r_gw; eth_n = r_eth; udp_n = r_udp; mag_n = r_mag;
        third_n = r_third; ent_n = r_ent; len_n = r_len; src_n = r_src;
        rs_n = r_rs; lay_a = r_lay;
        for (int i = 0; i < 32; i++) tb[i] = r_topic[i];
        if (take) begin
            if (p == PW'(12) || p == PW'(13)) begin
                gw_n = {r_gw[23:0], i_byte};
                if (p == PW'(13) && gw_n[15:0] == 16'h0800) eth_n = 1'b1;
            end
            if (p == PW'(14)) rs_n = 7'd22 + {1'b0, i_byte[3:0], 2'b00};
            if (p == PW'(23) && i_byte == 8'd17) udp_n = 1'b1;
            if (p >= PW'(26) && p <= PW'(29)) src_n = {r_src[23:0], i_byte};
        end
        if (in_r) begin
            if (off == PW'(0)) mag_n = (i_byte == 8'h52);
            if (off == PW'(1) && i_byte != 8'h54) mag_n = 1'b0;
            if (off == PW'(2) && i_byte != 8'h50) mag_n = 1'b0;
            if (off == PW'(3) && i_byte != 8'h53) mag_n = 1'b0;
            if (off == PW'(20))
                lay_a = (i_byte == SubInfoTs) ? LAY_TS :
                        (i_byte == SubInfoDst) ? LAY_DST : LAY_NONE;
            if (off == PW'(36) && lay_a == LAY_DST) begin
                if (i_byte == SubInfoTs) lay_a = LAY_THIRD;
                else if (i_byte != SubData) lay_a = LAY_NONE;
            end
            if (off == PW'(48) && lay_a == LAY_THIRD && i_byte == SubData) third_n = 1'b1;
        end
        lay_b = lay_a;
        es = (lay_b == LAY_TS) ? 7'd44 : 7'd48;
        ls = (lay_b == LAY_TS) ? 7'd84 : (lay_b == LAY_DST) ? 7'd88 : 7'd100;
        ts = ls + 7'd4;
        gw_sh = gw_n;
        if (in_r && lay_b != LAY_NONE) begin
            if (lay_b != LAY_THIRD && off >= PW'(es) && off <= PW'(es + 7'd3)) begin
                gw_sh = {gw_n[23:0], i_byte};
                if (off == PW'(es + 7'd3) && gw_sh == SedpEntity) ent_n = 1'b1;
            end
            if (off >= PW'(ls) && off <= PW'(ls + 7'd3)) begin
                gw_sh = {i_byte, gw_sh[31:8]};
                if (off == PW'(ls + 7'd3) &&
                    gw_sh <= ((lay_b == LAY_THIRD) ? 32'd32 : 32'd31)) len_n = 1'b1;
            end
            if (off >= PW'(ts) && off <= PW'(ts) + PW'(31))
                tb[5'(off - PW'(ts))] = i_byte;
        end
        len_tot = (PW+1)'(r_pos) + (PW+1)'(take);
        need = (PW+1)'(r_rs) + ((lay_b == LAY_TS) ? (PW+1)'(120) :
               (lay_b == LAY_DST) ? (PW+1)'(124) : (PW+1)'(136));
        o_job.filt = eth_n && udp_n && mag_n && len_n && lay_b != LAY_NONE &&
                     len_tot >= need && ((lay_b == LAY_THIRD) ? third_n : ent_n);
        cut = 1'b0;
        for (int i = 0; i < 32; i++) begin
            if (tb[i] == 8'd0) cut = 1'b1;
            o_job.topic[8*i +: 8] = cut ? 8'd0 : tb[i];
        end
        o_job.pair = {o_job.topic[223:0], src_n[7:0], src_n[15:8], src_n[23:16], src_n[31:24]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_byte_vld && i_end)) begin
            r_pos <= '0; r_rs <= '0; r_src <= '0; r_gw <= '0; r_lay <= LAY_NONE;
            r_eth <= 1'b0; r_udp <= 1'b0; r_mag <= 1'b0; r_third <= 1'b0;
            r_ent <= 1'b0; r_len <= 1'b0;
            for (int i = 0; i < 32; i++) r_topic[i] <= '0;
        end else if (i_byte_vld) begin
            r_pos <= r_pos + PW'(take); r_rs <= rs_n; r_src <= src_n; r_gw <= gw_sh;
            r_lay <= lay_b; r_eth <= eth_n; r_udp <= udp_n; r_mag <= mag_n;
            r_third <= third_n; r_ent <= ent_n; r_len <= len_n;
            for (int i = 0; i < 32; i++) r_topic[i] <= tb[i];
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte_vld && i_end) |=> (r_pos == '0)) else $error("pos not cleared");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_FRAME_BYTES)) else $error("pos overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lay == LAY_NONE) |-> !r_third) else $error("third without layout");
endmodule

@@ src/rtpf_back.sv @@
// Back end: searches the key table for the topic key then the pair key.
// Depends on rtpf_pkg and rtpf_ram.
`timescale 1ns / 1ps
module rtpf_back #(
    parameter int TABLE_ENTRIES = rtpf_pkg::TableEntriesDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_vld,
    output logic          o_job_rdy,
    input  rtpf_pkg::t_job i_job,
    input  logic          i_wr,
    input  logic [3:0]    i_wr_entry,
    input  logic [1:0]    i_wr_word,
    input  logic [63:0]   i_wr_data,
    input  logic          i_wr_valid,
    output logic          o_res_vld,
    input  logic          i_res_rdy,
    output logic [1:0]    o_cause
);
    import rtpf_pkg::*;
    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} t_state;
    t_state        r_st;
    t_job          r_job;
    logic          r_second;
    logic [EW-1:0] r_ent;
    logic [2:0]    r_wc;      // words issued 0..4
    logic          r_rv;      // read data valid next
    logic [1:0]    r_rw;
    logic          r_same;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [1:0]    r_cause;

    logic          wr_ok;
    logic [63:0]   rdata;
    logic [255:0]  key;
    logic          same_n;

    assign wr_ok = i_wr && ({28'd0, i_wr_entry} < TABLE_ENTRIES);
    rtpf_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES * 4)) u_ram (
        .i_clk(i_clk), .i_we(wr_ok),
        .i_waddr({EW'(i_wr_entry), i_wr_word}), .i_wdata(i_wr_data),
        .i_raddr({r_ent, r_wc[1:0]}), .o_rdata(rdata));

    assign key = r_second ? r_job.pair : r_job.topic;
    assign same_n = r_same && (rdata == key[64*r_rw +: 64]);
    assign o_job_rdy = (r_st == S_IDLE);
    assign o_res_vld = (r_st == S_DONE);
    assign o_cause = r_cause;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_valid <= '0; r_rv <= 1'b0;
        end else begin
            if (wr_ok) r_valid[EW'(i_wr_entry)] <= i_wr_valid;
            unique case (r_st)
                S_IDLE: if (i_job_vld) begin
                    r_job <= i_job;
                    if (!i_job.filt) begin
                        r_cause <= CAUSE_PASS; r_st <= S_DONE;
                    end else begin
                        r_second <= 1'b0; r_ent <= '0; r_wc <= '0;
                        r_rv <= 1'b0; r_same <= 1'b1; r_st <= S_READ;
                    end
                end
                S_READ: begin
                    r_rv <= (r_wc < 3'd4);
                    r_rw <= r_wc[1:0];
                    if (r_wc < 3'd4) r_wc <= r_wc + 3'd1;
                    if (r_rv) begin
                        r_same <= same_n;
                        if (r_rw == 2'd3) begin
                            r_rv <= 1'b0;
                            r_wc <= '0;
                            r_same <= 1'b1;
                            if (same_n && r_valid[r_ent]) begin
                                r_ent <= '0;
                                if (r_second) begin
                                    r_cause <= CAUSE_BOTH; r_st <= S_DONE;
                                end else r_second <= 1'b1;
                            end else if (32'(r_ent) == TABLE_ENTRIES - 1) begin
                                r_cause <= r_second ? CAUSE_PAIR : CAUSE_TOPIC;
                                r_st <= S_DONE;
                            end else r_ent <= r_ent + EW'(1);
                        end
                    end
                end
                S_DONE: if (i_res_rdy) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DONE && !i_res_rdy) |=> (r_st == S_DONE && $stable(r_cause)))
        else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_READ) |-> !o_job_rdy) else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_READ) |-> r_wc <= 3'd4) else $error("word count");
endmodule

@@ src/rtps_topic_packet_filter.sv @@
// Top level of the RTPS topic packet filter.
// Depends on rtpf_pkg, rtpf_front, rtpf_back, rtpf_ram.
//
//  channel  | dir | tdata (low bit up)                                  | tuser
//  s_axis   | in  | data_byte[7:0], entry_index[11:8], word_index[13:12],| cmd
//           |     | key_word[77:14], entry_valid[78], zero pad to 80     |
//           |     | tlast = frame_end                                    |
//  m_axis   | out | verdict_cause[1:0], zero pad to 8; tuser = drop      |
//
// Frame bytes go at one item per cycle while the input is not stalled. At a frame
// end the front hands a job to a two-entry queue; the back takes it when idle and
// walks the key table one 64-bit word per cycle from a single registered RAM read
// port, four reads plus a turnaround per entry, at most TABLE_ENTRIES entries per key,
// two keys at most, then the result waits for m_axis_tready. Input stalls when the
// queue is full; a table write also waits until the queue is empty and the back is
// idle, so it never reaches the table ahead of an earlier frame's verdict.
// Reset is synchronous, active low; the table contents are undefined until
// written, the valid marks clear at reset.
`timescale 1ns / 1ps
module rtps_topic_packet_filter #(
    parameter int TABLE_ENTRIES = rtpf_pkg::TableEntriesDef,
    parameter int MAX_FRAME_BYTES = rtpf_pkg::MaxFrameBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // data_byte, entry_index, word_index, key_word, entry_valid
    input  logic        s_axis_tlast,   // frame_end
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // verdict_cause
    output logic        m_axis_tuser    // drop
);
    import rtpf_pkg::*;

    logic   acc, byte_vld, wr;
    t_job   f_job, q_job;
    t_job   r_q [2];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    logic   q_rdy;
    logic   push, pop;
    logic [1:0] cause;

    // table writes hold off while any frame is queued, being searched or waiting for its verdict to be taken
    assign s_axis_tready = (r_cnt != 2'd2) && !(s_axis_tuser && (r_cnt != 2'd0 || !q_rdy));
    assign acc = s_axis_tvalid && s_axis_tready;
    assign byte_vld = acc && !s_axis_tuser;
    assign wr = acc && s_axis_tuser;
    assign push = byte_vld && s_axis_tlast;
    assign pop = (r_cnt != 2'd0) && q_rdy;
    assign q_job = r_q[r_rp];

    rtpf_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_byte_vld(byte_vld),
        .i_byte(s_axis_tdata[7:0]), .i_end(s_axis_tlast), .o_job(f_job));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= f_job; r_wp <= ~r_wp;
            end
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    rtpf_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_vld(r_cnt != 2'd0), .o_job_rdy(q_rdy),
        .i_job(q_job), .i_wr(wr), .i_wr_entry(s_axis_tdata[11:8]),
        .i_wr_word(s_axis_tdata[13:12]), .i_wr_data(s_axis_tdata[77:14]),
        .i_wr_valid(s_axis_tdata[78]), .o_res_vld(m_axis_tvalid),
        .i_res_rdy(m_axis_tready), .o_cause(cause));

    assign m_axis_tdata = {6'd0, cause};
    assign m_axis_tuser = (cause == CAUSE_TOPIC) || (cause == CAUSE_PAIR);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (cause == CAUSE_TOPIC || cause == CAUSE_PAIR)))
        else $error("drop mismatch");
endmodule

@@ tb/sv/rtpf_checker.sv @@
// Checker for the RTPS topic packet filter: watches both stream channels, keeps its own
// copy of the key table and frame state, predicts each verdict and compares it.
// Depends on rtpf_pkg.
`timescale 1ns / 1ps
module rtpf_checker
    import rtpf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MaxFrameBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [79:0] i_s_tdata,   // data_byte, entry_index, word_index, key_word, entry_valid
    input  logic        i_s_tlast,   // frame_end
    input  logic        i_s_tuser,   // cmd
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // verdict_cause
    input  logic        i_m_tuser,   // drop
    output int          o_fail_count,
    output int          o_pending
);
    localparam logic [31:0] MagicWord = 32'h5254_5053;  // "RTPS"

    typedef struct packed {
        logic   drop;
        t_cause cause;
    } t_verdict;

    t_verdict   verdict_q[$];
    logic [63:0] key_words [TableEntriesDef][4];
    logic        key_ok [TableEntriesDef];
    int          byte_pos, rtps_at;
    logic [7:0]  topic [32];
    logic [31:0] src_ip, gword;
    logic        f_eth, f_udp, f_magic, f_third, f_entity, f_len;
    t_layout     lay;

    function automatic void clear_frame();
        byte_pos = 0;
        rtps_at = 0;
        foreach (topic[i]) topic[i] = 8'h00;
        src_ip = '0;
        gword = '0;
        {f_eth, f_udp, f_magic, f_third, f_entity, f_len} = '0;
        lay = LAY_NONE;
    endfunction

    function automatic void take_byte(int p, logic [7:0] b);
        int off, es, ls, ts;
        if (p == 12 || p == 13) begin
            gword = {gword[23:0], b};
            if (p == 13 && gword[15:0] == 16'h0800) f_eth = 1'b1;
        end
        if (p == 14) rtps_at = 22 + 4 * b[3:0];
        if (p == 23 && b == 8'd17) f_udp = 1'b1;
        if (p >= 26 && p <= 29) src_ip = {src_ip[23:0], b};
        if (p > 14 && p >= rtps_at) begin
            off = p - rtps_at;
            if (off < 4) begin
                if (off == 0) f_magic = (b == MagicWord[31:24]);
                else if (b != MagicWord[8*(3-off) +: 8]) f_magic = 1'b0;
            end
            if (off == 20)
                lay = (b == SubInfoTs) ? LAY_TS : ((b == SubInfoDst) ? LAY_DST : LAY_NONE);
            if (off == 36 && lay == LAY_DST) begin
                if (b == SubInfoTs) lay = LAY_THIRD;
                else if (b != SubData) lay = LAY_NONE;
            end
            if (off == 48 && lay == LAY_THIRD && b == SubData) f_third = 1'b1;
            if (lay != LAY_NONE) begin
                es = (lay == LAY_TS) ? 44 : 48;
                ls = (lay == LAY_TS) ? 84 : ((lay == LAY_DST) ? 88 : 100);
                ts = ls + 4;
                if (lay != LAY_THIRD && off >= es && off <= es + 3) begin
                    gword = {gword[23:0], b};
                    if (off == es + 3 && gword == SedpEntity) f_entity = 1'b1;
                end
                if (off >= ls && off <= ls + 3) begin
                    gword = {b, gword[31:8]};   // little-endian length
                    if (off == ls + 3 && gword <= ((lay == LAY_THIRD) ? 32 : 31))
                        f_len = 1'b1;
                end
                if (off >= ts && off <= ts + 31) topic[off - ts] = b;
            end
        end
    endfunction

    function automatic logic key_present(logic [255:0] k);
        for (int e = 0; e < TableEntriesDef; e++)
            if (key_ok[e] && {key_words[e][3], key_words[e][2], key_words[e][1],
                              key_words[e][0]} == k)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_cause frame_cause();
        int need;
        logic [255:0] tkey, pkey;
        logic cut;
        need = (lay == LAY_TS) ? 120 : ((lay == LAY_DST) ? 124 : 136);
        if (!(f_eth && f_udp && f_magic && f_len)) return CAUSE_PASS;
        if (lay == LAY_NONE || byte_pos < rtps_at + need) return CAUSE_PASS;
        if (!((lay == LAY_THIRD) ? f_third : f_entity)) return CAUSE_PASS;
        cut = 1'b0;
        for (int i = 0; i < 32; i++) begin
            if (topic[i] == 8'h00) cut = 1'b1;
            tkey[8*i +: 8] = cut ? 8'h00 : topic[i];
        end
        if (!key_present(tkey)) return CAUSE_TOPIC;
        pkey = {tkey[223:0], src_ip[7:0], src_ip[15:8], src_ip[23:16], src_ip[31:24]};
        if (!key_present(pkey)) return CAUSE_PAIR;
        return CAUSE_BOTH;
    endfunction

    always @(posedge i_clk) begin
        t_verdict v, got;
        int fails;
        fails = 0;
        if (!i_rst_n) begin
            foreach (key_ok[e]) key_ok[e] = 1'b0;
            clear_frame();
            verdict_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) begin
                    key_words[i_s_tdata[11:8]][i_s_tdata[13:12]] = i_s_tdata[77:14];
                    key_ok[i_s_tdata[11:8]] = i_s_tdata[78];
                end else begin
                    if (byte_pos < MAX_FRAME_BYTES) begin
                        take_byte(byte_pos, i_s_tdata[7:0]);
                        byte_pos++;
                    end
                    if (i_s_tlast) begin
                        v.cause = frame_cause();
                        v.drop = (v.cause == CAUSE_TOPIC || v.cause == CAUSE_PAIR);
                        verdict_q.push_back(v);
                        clear_frame();
                    end
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict with none expected: cause %0d drop %0d",
                           i_m_tdata[1:0], i_m_tuser);
                    fails++;
                end else begin
                    v = verdict_q.pop_front();
                    got.cause = t_cause'(i_m_tdata[1:0]);
                    got.drop = i_m_tuser;
                    if (got.cause != v.cause || i_m_tdata[7:2] != '0) begin
                        $error("verdict_cause: expected %0d, got %0d", v.cause, i_m_tdata);
                        fails++;
                    end
                    if (got.drop != v.drop) begin
                        $error("drop: expected %0d, got %0d", v.drop, got.drop);
                        fails++;
                    end
                end
            end
            o_fail_count <= o_fail_count + fails;
        end
        o_pending <= verdict_q.size();
    end
endmodule

@@ tb/sv/tb.sv @@
// Top of the RTPS topic packet filter testbench: clock, reset, frame and table-write
// stimulus, receiver backpressure, watchdog and verdict. Depends on rtpf_pkg,
// rtps_topic_packet_filter and rtpf_checker.
`timescale 1ns / 1ps
module tb;
    import rtpf_pkg::*;

    localparam int StallLimit = 4000;   // cycles without any accepted item
    localparam int HoldCycles = 400;    // long receiver hold-off
    localparam int MaxFrameBytes = 256; // frame length cap, above every well-formed frame

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // data_byte, entry_index, word_index, key_word, entry_valid
    logic        s_axis_tlast = 1'b0; // frame_end
    logic        s_axis_tuser = 1'b0; // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // verdict_cause
    logic        m_axis_tuser;        // drop
    int          fail_count, pending;

    int tx_idle = 0, rx_idle = 0;     // idle percentages per side
    int hold_asked = 0, hold_done = 0, hold_left = 0;
    int items_sent = 0, frames_sent = 0;

    // key pool: a few topic names and source addresses, so all verdict kinds show up
    logic [255:0] topic_pool [4];
    logic [31:0]  src_pool [3];
    logic [255:0] table_copy [TableEntriesDef];
    logic [7:0]   frame_q [$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rtps_topic_packet_filter #(.MAX_FRAME_BYTES(MaxFrameBytes)) dut (.*);

    rtpf_checker #(.MAX_FRAME_BYTES(MaxFrameBytes)) chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_s_tlast(s_axis_tlast), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_m_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_asked != hold_done) begin
            hold_done <= hold_asked;
            hold_left <= HoldCycles;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // watchdog: any accepted item on either side restarts the count
    always @(posedge i_clk) begin
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= StallLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one item on the input channel; returns after it was accepted
    task automatic send_item(logic cmd, logic [7:0] b, logic last, logic [3:0] entry,
                             logic [1:0] word, logic [63:0] kw, logic valid);
        if ($urandom_range(0, 99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tlast <= last;
        s_axis_tdata <= {1'b0, valid, kw, word, entry, b};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_key(int e, logic [255:0] k, logic valid);
        table_copy[e] = k;
        for (int w = 0; w < 4; w++)
            send_item(1'b1, 8'($urandom()), 1'($urandom()), e[3:0], w[1:0],
                      k[64*w +: 64], valid);
    endtask

    // stray table write: rewrites a word of entries 0..7 with its own value, or gives entry 8
    // or one of the spare entries a fresh random word; either way with a random valid mark
    task automatic stray_write();
        int e;
        int w;
        logic [63:0] kw;
        e = $urandom_range(0, TableEntriesDef - 1);
        w = $urandom_range(0, 3);
        kw = (e >= 8) ? {$urandom(), $urandom()} : table_copy[e][64*w +: 64];
        table_copy[e][64*w +: 64] = kw;
        send_item(1'b1, 8'($urandom()), 1'($urandom()), e[3:0], w[1:0], kw,
                  $urandom_range(0, 3) != 0);
    endtask

    task automatic send_frame(logic with_writes);
        for (int i = 0; i < frame_q.size(); i++) begin
            if (with_writes && $urandom_range(0, 99) < 3) stray_write();
            send_item(1'b0, frame_q[i], i == frame_q.size() - 1, 4'($urandom()),
                      2'($urandom()), {$urandom(), $urandom()}, 1'($urandom()));
        end
        frames_sent++;
    endtask

    // builds a well-formed frame of the given layout; the topic carries a name from the
    // pool (or a random one) in 32 bytes, shorter pool names zero-padded, then optional junk
    task automatic build_frame(t_layout lay, int ihl, int tsel, int ssel, logic [31:0] tlen,
                               int extra);
        int r, es, ls, need, n;
        logic [255:0] name;
        logic [31:0] sip;
        r = 22 + 4 * ihl;
        es = (lay == LAY_TS) ? 44 : 48;
        ls = (lay == LAY_TS) ? 84 : ((lay == LAY_DST) ? 88 : 100);
        need = ls + 36;
        n = r + need + extra;
        name = (tsel < 4) ? topic_pool[tsel] : {8{$urandom()}};
        sip = (ssel < 3) ? src_pool[ssel] : $urandom();
        frame_q.delete();
        for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom()));
        frame_q[12] = 8'h08;
        frame_q[13] = 8'h00;
        frame_q[14] = {4'h4, ihl[3:0]};
        frame_q[23] = 8'd17;
        for (int i = 0; i < 4; i++) frame_q[26 + i] = sip[8*(3-i) +: 8];
        frame_q[r] = "R";
        frame_q[r + 1] = "T";
        frame_q[r + 2] = "P";
        frame_q[r + 3] = "S";
        frame_q[r + 20] = (lay == LAY_TS) ? SubInfoTs : SubInfoDst;
        if (lay == LAY_DST) frame_q[r + 36] = SubData;
        if (lay == LAY_THIRD) begin
            frame_q[r + 36] = SubInfoTs;
            frame_q[r + 48] = SubData;
        end else begin
            for (int i = 0; i < 4; i++) frame_q[r + es + i] = SedpEntity[8*(3-i) +: 8];
        end
        for (int i = 0; i < 4; i++) frame_q[r + ls + i] = tlen[8*i +: 8];
        for (int i = 0; i < 32; i++) frame_q[r + ls + 4 + i] = name[8*i +: 8];
    endtask

    task automatic random_frame();
        int mode, tl, n;
        t_layout lay;
        mode = $urandom_range(0, 99);
        lay = t_layout'($urandom_range(1, 3));
        tl = (lay == LAY_THIRD) ? 32 : 31;
        build_frame(lay, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5,
                    $urandom_range(0, 4), $urandom_range(0, 3),
                    ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, tl),
                    $urandom_range(0, 6));
        if (mode < 15) begin
            frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom());
        end else if (mode < 25) begin
            n = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > n) void'(frame_q.pop_back());
        end else if (mode < 40) begin
            frame_q.delete();
            repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom()));
        end
        send_frame(1'b1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [255:0] k;
        int len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pool of names: 1..32 nonzero bytes, zero-padded
        for (int t = 0; t < 4; t++) begin
            len = (t == 0) ? 32 : $urandom_range(1, 31);
            topic_pool[t] = '0;
            for (int i = 0; i < len; i++) topic_pool[t][8*i +: 8] = 8'($urandom_range(1, 255));
        end
        foreach (src_pool[s]) src_pool[s] = $urandom();

        // every word of every entry gets written before any entry turns valid
        for (int e = 0; e < TableEntriesDef; e++)
            write_key(e, {8{$urandom()}}, 1'b0);
        for (int t = 0; t < 4; t++) begin
            write_key(t, topic_pool[t], t != 3);
            k = {topic_pool[t][223:0], src_pool[t % 3][7:0], src_pool[t % 3][15:8],
                 src_pool[t % 3][23:16], src_pool[t % 3][31:24]};
            write_key(4 + t, k, 1'b1);
        end
        write_key(8, '1, 1'b1);

        tx_idle = 15;
        rx_idle = 51;

        // directed: each layout with keys found, a missing topic and a missing pair, IHL extremes, length limits
        build_frame(LAY_TS, 0, 0, 0, 31, 0);     send_frame(1'b0);   // overlapping header
        build_frame(LAY_DST, 0, 1, 1, 0, 0);     send_frame(1'b0);
        build_frame(LAY_THIRD, 0, 2, 2, 32, 0);  send_frame(1'b0);
        build_frame(LAY_TS, 0, 1, 0, 5, 0);      send_frame(1'b0);   // pair missing
        build_frame(LAY_THIRD, 15, 4, 1, 3, 2);  send_frame(1'b0);   // random topic
        build_frame(LAY_DST, 0, 0, 0, 32, 0);    send_frame(1'b0);   // length one too big
        build_frame(LAY_TS, 0, 0, 0, 31, 0);
        void'(frame_q.pop_back());
        send_frame(1'b0);                                           // one byte short
        frame_q = '{8'hFF};                      send_frame(1'b0);   // single-byte frame
        frame_q = '{8'h00};                      send_frame(1'b0);
        build_frame(LAY_TS, 0, 1, 1, 31, 0);                        // oversize, still found
        while (frame_q.size() < MaxFrameBytes + 20) frame_q.push_back(8'($urandom()));
        send_frame(1'b0);

        // long hold-off while short frames keep coming: the job queue fills and
        // the input stalls
        hold_asked++;
        repeat (12) begin
            frame_q = '{8'h55, 8'hAA};
            send_frame(1'b0);
        end
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 15 : ((ph == 1) ? 51 : 0);
            rx_idle = (ph == 0) ? 51 : ((ph == 1) ? 15 : 0);
            len = items_sent;
            k[31:0] = frames_sent;
            while (items_sent - len < 100 || frames_sent - k[31:0] < 2) random_frame();
            if (ph == 1) wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
